[design/rhsv_pkg.sv]
// Shared types and constants for the RGB to HSV converter.
// Used by rhsv_prep, rhsv_cell and rgb_to_hsv_converter_top; depends on nothing.
`default_nettype none

package rhsv_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned HUE_W   = 15;
  localparam int unsigned SAT_W   = 13;
  localparam int unsigned NUM_W   = 21;
  localparam int unsigned DIV_W   = CHAN_W + 1;
  localparam int unsigned QUO_W   = 13;
  localparam int unsigned CELLS   = QUO_W;
  localparam int unsigned HQ_W    = 12;

  localparam logic [12:0]      HUE_SIXTH2 = 13'd7680;
  localparam logic [HUE_W-1:0] HUE_GREEN  = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_BLUE   = 15'd15360;
  localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // One lane of the restoring divider as it moves down the cell row.
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] num;
    logic [DIV_W-1:0] dvs;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  // Per-pixel control that travels alongside the two divider lanes.
  typedef struct packed {
    logic              valid;
    sector_t           sector;
    logic              negative;
    logic              grey;
    logic [CHAN_W-1:0] brightness;
  } side_t;

endpackage

`default_nettype wire

[design/rhsv_prep.sv]
// Front stage: max, min, delta, hue sector and the divider operands.
// Depends on rhsv_pkg.
`default_nettype none

module rhsv_prep
  import rhsv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [CHAN_W-1:0] red,
  input  wire logic [CHAN_W-1:0] green,
  input  wire logic [CHAN_W-1:0] blue,
  output      side_t             side_out,
  output      div_lane_t         hue_out,
  output      div_lane_t         sat_out
);

  logic [CHAN_W-1:0] mx;
  logic [CHAN_W-1:0] mn;
  logic [CHAN_W-1:0] delta;
  logic [CHAN_W-1:0] pos;
  logic [CHAN_W-1:0] neg;
  logic [CHAN_W-1:0] mag;
  logic              negative;
  sector_t           sector;
  logic [NUM_W-1:0]  hue_num;
  logic [NUM_W-1:0]  sat_num;
  side_t             side_next;
  div_lane_t         hue_next;
  div_lane_t         sat_next;

  always_comb begin
    mx = (red > green) ? red : green;
    if (blue > mx) begin
      mx = blue;
    end
    mn = (red < green) ? red : green;
    if (blue < mn) begin
      mn = blue;
    end
    delta = mx - mn;

    // Ties go to red first, then green.
    if (mx == red) begin
      sector = SECT_RED;
    end else if (mx == green) begin
      sector = SECT_GREEN;
    end else begin
      sector = SECT_BLUE;
    end

    unique case (sector)
      SECT_RED: begin
        pos = green;
        neg = blue;
      end
      SECT_GREEN: begin
        pos = blue;
        neg = red;
      end
      default: begin
        pos = red;
        neg = green;
      end
    endcase

    negative = pos < neg;
    mag      = negative ? (neg - pos) : (pos - neg);

    // Adding half the divisor turns the floor division into rounding.
    hue_num = NUM_W'(mag) * NUM_W'(HUE_SIXTH2) + NUM_W'(delta);
    sat_num = {delta, 13'd0} + NUM_W'(mx);

    hue_next.rem = {1'b0, hue_num[NUM_W-1:QUO_W]};
    hue_next.num = hue_num[QUO_W-1:0];
    hue_next.dvs = {delta, 1'b0};
    hue_next.quo = '0;

    sat_next.rem = {1'b0, sat_num[NUM_W-1:QUO_W]};
    sat_next.num = sat_num[QUO_W-1:0];
    sat_next.dvs = {mx, 1'b0};
    sat_next.quo = '0;

    side_next.valid      = accept;
    side_next.sector     = sector;
    side_next.negative   = negative;
    side_next.grey       = (delta == '0);
    side_next.brightness = mx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out.valid <= side_next.valid;
    end
    side_out.sector     <= side_next.sector;
    side_out.negative   <= side_next.negative;
    side_out.grey       <= side_next.grey;
    side_out.brightness <= side_next.brightness;
    hue_out             <= hue_next;
    sat_out             <= sat_next;
  end

endmodule

`default_nettype wire

[design/rhsv_cell.sv]
// One divider cell: produces one quotient bit for the hue and saturation lanes.
// Depends on rhsv_pkg.
`default_nettype none

module rhsv_cell
  import rhsv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire side_t     side_in,
  input  wire div_lane_t hue_in,
  input  wire div_lane_t sat_in,
  output      side_t     side_out,
  output      div_lane_t hue_out,
  output      div_lane_t sat_out
);

  function automatic div_lane_t lane_step(input div_lane_t l);
    logic [DIV_W:0] trial;
    logic           fits;
    div_lane_t      r;
    trial = {l.rem, l.num[QUO_W-1]};
    fits  = trial >= {1'b0, l.dvs};
    r.rem = fits ? DIV_W'(trial - {1'b0, l.dvs}) : trial[DIV_W-1:0];
    r.num = {l.num[QUO_W-2:0], 1'b0};
    r.dvs = l.dvs;
    r.quo = {l.quo[QUO_W-2:0], fits};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out.valid <= side_in.valid;
    end
    side_out.sector     <= side_in.sector;
    side_out.negative   <= side_in.negative;
    side_out.grey       <= side_in.grey;
    side_out.brightness <= side_in.brightness;
    hue_out             <= lane_step(hue_in);
    sat_out             <= lane_step(sat_in);
  end

endmodule

`default_nettype wire

[design/rgb_to_hsv_converter_top.sv]
// RGB to HSV converter: one pixel per cycle, except while rst is high.
// Timing: one front register, thirteen divider cells (one quotient bit each), one output register.
// The row of divider cells sets the latency; every stage takes a new pixel each cycle.
// Reset clears all valid flags; busy is high only while rst is high.
// done pulses for exactly one cycle per transaction and cannot be held off.
// Depends on rhsv_pkg, rhsv_prep and rhsv_cell.
`default_nettype none

module rgb_to_hsv_converter_top
  import rhsv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic [CHAN_W-1:0] red,
  input  wire logic [CHAN_W-1:0] green,
  input  wire logic [CHAN_W-1:0] blue,
  output      logic              done,
  output      logic [HUE_W-1:0]  hue,
  output      logic [SAT_W-1:0]  saturation,
  output      logic [CHAN_W-1:0] brightness
);

  // Stage 0 is the front register; stage k+1 is the output of cell k.
  side_t     side_q [CELLS+1];
  div_lane_t hue_q  [CELLS+1];
  div_lane_t sat_q  [CELLS+1];

  logic             accept;
  logic [HQ_W-1:0]  hue_quo;
  logic [HUE_W:0]   hue_sum;
  logic [HUE_W-1:0] offset;
  logic [HUE_W-1:0] hue_next;
  logic [SAT_W-1:0] sat_next;
  side_t            last;

  // The pipeline has no stall, so the only time a transaction is refused is reset.
  assign busy   = rst;
  assign accept = start && !busy;

  rhsv_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .side_out (side_q[0]),
    .hue_out  (hue_q[0]),
    .sat_out  (sat_q[0])
  );

  // Each cell resolves one quotient bit, most significant first, for both divisions.
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    rhsv_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .side_in  (side_q[k]),
      .hue_in   (hue_q[k]),
      .sat_in   (sat_q[k]),
      .side_out (side_q[k+1]),
      .hue_out  (hue_q[k+1]),
      .sat_out  (sat_q[k+1])
    );
  end

  assign last = side_q[CELLS];

  // The hue magnitude never exceeds 3840, so its top quotient bit is always zero.
  assign hue_quo = hue_q[CELLS].quo[HQ_W-1:0];

  always_comb begin
    unique case (last.sector)
      SECT_RED:   offset = '0;
      SECT_GREEN: offset = HUE_GREEN;
      default:    offset = HUE_BLUE;
    endcase

    // A magnitude larger than the offset only happens in the red sector;
    // the hue then wraps around by a full turn.
    if (!last.negative) begin
      hue_sum = {1'b0, offset} + (HUE_W + 1)'(hue_quo);
    end else if ((HUE_W + 1)'(hue_quo) > {1'b0, offset}) begin
      hue_sum = {1'b0, offset} + {1'b0, HUE_FULL} - (HUE_W + 1)'(hue_quo);
    end else begin
      hue_sum = {1'b0, offset} - (HUE_W + 1)'(hue_quo);
    end

    hue_next = last.grey ? '0 : hue_sum[HUE_W-1:0];
    // A black pixel divides by zero; its saturation is forced to zero.
    sat_next = (last.brightness == '0) ? '0 : sat_q[CELLS].quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
    hue        <= hue_next;
    saturation <= sat_next;
    brightness <= last.brightness;
  end

  a_hue_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (hue < HUE_FULL))
    else $error("hue out of range");

  a_sat_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (saturation <= SAT_W'(4096)))
    else $error("saturation out of range");

  a_black : assert property (@(posedge clk) disable iff (rst)
    (done && brightness == '0) |-> (hue == '0 && saturation == '0))
    else $error("black pixel must give zero hue and saturation");

  a_pipe_valid : assert property (@(posedge clk) disable iff (rst)
    last.valid |=> done)
    else $error("result lost between last cell and output register");

endmodule

`default_nettype wire
